[hdl/mscc_pkg.sv]
// Shared types, opcodes and constants for the MIPS single-cycle core.
`timescale 1ns / 1ps

package mscc_pkg;

    // Data memory geometry
    localparam int DATA_WORDS = 65536;
    localparam int DMEM_AW    = $clog2(DATA_WORDS);

    // Register file geometry
    localparam int RF_DEPTH = 32;
    localparam int RF_AW    = 5;

    // Architectural reset values
    localparam logic [31:0] SP_RESET = 32'h0010_0000;
    localparam logic [31:0] RA_RESET = 32'hFFFF_FFFF;
    localparam logic [31:0] HALT_PC  = 32'hFFFF_FFFF;
    localparam logic [RF_AW-1:0] REG_SP = 5'd29;
    localparam logic [RF_AW-1:0] REG_RA = 5'd31;
    localparam logic [RF_AW-1:0] REG_ZERO = 5'd0;

    // Primary opcodes
    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // Function codes of the register-type group
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    // Instruction class codes reported on the result
    localparam logic [1:0] CLS_NOP = 2'd0;
    localparam logic [1:0] CLS_R   = 2'd1;
    localparam logic [1:0] CLS_I   = 2'd2;
    localparam logic [1:0] CLS_J   = 2'd3;

    // Outcome of executing one instruction
    typedef struct packed {
        logic [31:0]      next_pc;
        logic             reg_write;
        logic [RF_AW-1:0] reg_index;
        logic [31:0]      reg_value;
        logic             mem_read;
        logic             mem_write;
        logic [31:0]      mem_address;
        logic             branch_taken;
        logic [1:0]       inst_class;
    } exec_res_t;

    // Register contents before the first write to an entry
    function automatic logic [31:0] reg_reset_value(input logic [RF_AW-1:0] idx);
        logic [31:0] val;
        begin
            val = 32'd0;
            if (idx == REG_SP)
            begin
                val = SP_RESET;
            end
            else if (idx == REG_RA)
            begin
                val = RA_RESET;
            end
            return val;
        end
    endfunction

endpackage

[hdl/mscc_if.sv]
// Valid/ready channel interfaces for instruction and result items.
`timescale 1ns / 1ps

interface mscc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink (input valid, input instruction, output ready);
endinterface

interface mscc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_address;
    logic        halted;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [31:0] mem_address;
    logic        branch_taken;
    logic [1:0]  inst_class;

    modport source (output valid, output fetch_address, output halted, output reg_write,
                    output reg_index, output reg_value, output mem_write,
                    output mem_address, output branch_taken, output inst_class,
                    input ready);
    modport sink (input valid, input fetch_address, input halted, input reg_write,
                  input reg_index, input reg_value, input mem_write,
                  input mem_address, input branch_taken, input inst_class,
                  output ready);
endinterface

[hdl/mscc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mscc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read; hold the last word when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/mscc_exec.sv]
// Instruction decode and execute: next pc, write-back, memory address, class.
`timescale 1ns / 1ps

module mscc_exec (
    input  logic [31:0]          instruction,
    input  logic [31:0]          pc,
    input  logic [31:0]          a,
    input  logic [31:0]          b,
    output mscc_pkg::exec_res_t  res
);

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] sum_imm;
    logic        slt_ab;
    logic        slt_aimm;
    logic        we;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic [31:0] next;
    logic        mr;
    logic        mw;
    logic        taken;
    logic [31:0] maddr;
    logic [1:0]  cls;

    assign op   = instruction[31:26];
    assign rt   = instruction[20:16];
    assign rd   = instruction[15:11];
    assign sh   = instruction[10:6];
    assign fn   = instruction[5:0];
    assign imm  = {16'd0, instruction[15:0]};
    assign simm = {{16{instruction[15]}}, instruction[15:0]};
    assign pc4  = pc + 32'd4;

    // Shared adder for addi, lw and sw; signed compares flip the sign bit
    assign sum_imm  = a + simm;
    assign slt_ab   = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
    assign slt_aimm = (a ^ 32'h8000_0000) < (simm ^ 32'h8000_0000);

    // Decode and execute
    always_comb
    begin
        we    = 1'b0;
        widx  = rt;
        wval  = 32'd0;
        next  = pc4;
        mr    = 1'b0;
        mw    = 1'b0;
        taken = 1'b0;
        maddr = 32'd0;
        if (op == mscc_pkg::OP_RTYPE)
        begin
            we   = 1'b1;
            widx = rd;
            unique case (fn) inside
                mscc_pkg::FN_ADD, mscc_pkg::FN_ADDU: wval = a + b;
                mscc_pkg::FN_SUB, mscc_pkg::FN_SUBU: wval = a - b;
                mscc_pkg::FN_AND:  wval = a & b;
                mscc_pkg::FN_OR:   wval = a | b;
                mscc_pkg::FN_NOR:  wval = ~(a | b);
                mscc_pkg::FN_SLT:  wval = {31'd0, slt_ab};
                mscc_pkg::FN_SLTU: wval = {31'd0, a < b};
                mscc_pkg::FN_SLL:  wval = b << sh;
                mscc_pkg::FN_SRL:  wval = b >> sh;
                mscc_pkg::FN_JR:
                begin
                    we   = 1'b0;
                    next = a;
                end
                mscc_pkg::FN_JALR:
                begin
                    wval = pc4;
                    next = a;
                end
                default: we = 1'b0;
            endcase
        end
        else
        begin
            unique case (op) inside
                mscc_pkg::OP_ADDI, mscc_pkg::OP_ADDIU:
                begin
                    we   = 1'b1;
                    wval = sum_imm;
                end
                mscc_pkg::OP_ANDI:
                begin
                    we   = 1'b1;
                    wval = a & imm;
                end
                mscc_pkg::OP_ORI:
                begin
                    we   = 1'b1;
                    wval = a | imm;
                end
                mscc_pkg::OP_LUI:
                begin
                    we   = 1'b1;
                    wval = {instruction[15:0], 16'd0};
                end
                mscc_pkg::OP_SLTI:
                begin
                    we   = 1'b1;
                    wval = {31'd0, slt_aimm};
                end
                mscc_pkg::OP_SLTIU:
                begin
                    we   = 1'b1;
                    wval = {31'd0, a < simm};
                end
                mscc_pkg::OP_LW:
                begin
                    // Value arrives from the data memory's read register in the result stage
                    we    = 1'b1;
                    mr    = 1'b1;
                    maddr = sum_imm;
                end
                mscc_pkg::OP_SW:
                begin
                    mw    = 1'b1;
                    maddr = sum_imm;
                end
                mscc_pkg::OP_BEQ, mscc_pkg::OP_BNE:
                begin
                    taken = (op == mscc_pkg::OP_BEQ) ? (a == b) : (a != b);
                    if (taken)
                    begin
                        next = pc4 + {simm[29:0], 2'b00};
                    end
                end
                mscc_pkg::OP_J, mscc_pkg::OP_JAL:
                begin
                    next = {pc4[31:28], instruction[25:0], 2'b00};
                    if (op == mscc_pkg::OP_JAL)
                    begin
                        we   = 1'b1;
                        widx = mscc_pkg::REG_RA;
                        wval = pc4 + 32'd4;
                    end
                end
                default: we = 1'b0;
            endcase
        end
    end

    // Classify the instruction word
    always_comb
    begin
        if (instruction == 32'd0)
        begin
            cls = mscc_pkg::CLS_NOP;
        end
        else if (op == mscc_pkg::OP_RTYPE)
        begin
            cls = mscc_pkg::CLS_R;
        end
        else if (op == mscc_pkg::OP_J || op == mscc_pkg::OP_JAL)
        begin
            cls = mscc_pkg::CLS_J;
        end
        else
        begin
            cls = mscc_pkg::CLS_I;
        end
    end

    // Drop writes to register zero
    always_comb
    begin
        res              = '0;
        res.next_pc      = next;
        res.mem_write    = mw;
        res.mem_address  = maddr;
        res.branch_taken = taken;
        res.inst_class   = cls;
        if (we && widx != mscc_pkg::REG_ZERO)
        begin
            res.reg_write = 1'b1;
            res.reg_index = widx;
            res.reg_value = wval;
            res.mem_read  = mr;
        end
    end

endmodule

[hdl/mips_single_cycle_core.sv]
// Top level of the MIPS32 integer core: register file, data memory and pipeline control.
`timescale 1ns / 1ps

//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  in_ch    | in        | instruction
//  out_ch   | out       | fetch_address, halted, reg_write, reg_index, reg_value,
//           |           | mem_write, mem_address, branch_taken, inst_class
//
//  An item's result is offered from the result register: the register file
//  is read at acceptance, execute and data memory access work on the execute-stage
//  registers, and the result register loads when the pipeline next advances. One item
//  is accepted every cycle while no result waits unread and no clearing pass runs;
//  results of older items are forwarded to the execute stage. After reset the data
//  memory is zeroed one word a cycle, and no item is accepted until that pass ends.
//  The whole pipeline advances together and holds while a result waits unread.

module mips_single_cycle_core (
    input  logic            clk,
    input  logic            rst_n,
    mscc_in_if.sink         in_ch,
    mscc_out_if.source      out_ch
);

    localparam logic [mscc_pkg::DMEM_AW-1:0] CLR_LAST =
        mscc_pkg::DMEM_AW'(mscc_pkg::DATA_WORDS - 1);

    logic                          advance;
    logic                          in_acc;
    logic                          commit;

    // Clearing pass
    logic                          clr_active_reg;
    logic [mscc_pkg::DMEM_AW-1:0]  clr_addr_reg;

    // Execute stage
    logic                          s1_vld_reg;
    logic [31:0]                   s1_ins_reg;
    logic                          s1_a_ok_reg;
    logic                          s1_b_ok_reg;
    logic [31:0]                   pc_reg;

    // Result stage
    logic                          s2_vld_reg;
    logic [31:0]                   s2_next_pc_reg;
    logic                          s2_we_reg;
    logic [4:0]                    s2_idx_reg;
    logic [31:0]                   s2_val_reg;
    logic                          s2_load_reg;
    logic                          s2_mw_reg;
    logic [31:0]                   s2_maddr_reg;
    logic                          s2_taken_reg;
    logic [1:0]                    s2_cls_reg;
    logic [31:0]                   s2_value;

    // Register file state
    logic [mscc_pkg::RF_DEPTH-1:0] rf_valid_reg;
    logic                          lc_vld_reg;
    logic [4:0]                    lc_idx_reg;
    logic [31:0]                   lc_val_reg;
    logic [31:0]                   rf_qa;
    logic [31:0]                   rf_qb;

    logic [4:0]                    s1_rs;
    logic [4:0]                    s1_rt;
    logic [31:0]                   opa;
    logic [31:0]                   opb;
    mscc_pkg::exec_res_t           res;

    logic                          dm_we;
    logic [mscc_pkg::DMEM_AW-1:0]  dm_waddr;
    logic [31:0]                   dm_wdata;
    logic                          dm_re;
    logic [mscc_pkg::DMEM_AW-1:0]  dm_idx;
    logic [31:0]                   dm_q;

    // Handshake and pipeline advance
    assign advance     = !s2_vld_reg || out_ch.ready;
    assign in_ch.ready = advance && !clr_active_reg;
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign commit      = s2_vld_reg && out_ch.ready && s2_we_reg;

    // Sweep the data memory to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == CLR_LAST)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Register file: two copies give two read ports
    mscc_ram #(.WIDTH(32), .DEPTH(mscc_pkg::RF_DEPTH)) u_rf_a (
        .clk   (clk),
        .we    (commit),
        .waddr (s2_idx_reg),
        .wdata (s2_value),
        .re    (in_acc),
        .raddr (in_ch.instruction[25:21]),
        .rdata (rf_qa)
    );

    mscc_ram #(.WIDTH(32), .DEPTH(mscc_pkg::RF_DEPTH)) u_rf_b (
        .clk   (clk),
        .we    (commit),
        .waddr (s2_idx_reg),
        .wdata (s2_value),
        .re    (in_acc),
        .raddr (in_ch.instruction[20:16]),
        .rdata (rf_qb)
    );

    // Track written entries and the most recent write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            lc_vld_reg   <= 1'b0;
        end
        else if (commit)
        begin
            rf_valid_reg[s2_idx_reg] <= 1'b1;
            lc_vld_reg               <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            lc_idx_reg <= s2_idx_reg;
            lc_val_reg <= s2_value;
        end
    end

    // Advance the execute stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            pc_reg     <= '0;
        end
        else if (advance)
        begin
            s1_vld_reg <= in_acc;
            if (s1_vld_reg)
            begin
                pc_reg <= res.next_pc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_ins_reg  <= in_ch.instruction;
            s1_a_ok_reg <= rf_valid_reg[in_ch.instruction[25:21]];
            s1_b_ok_reg <= rf_valid_reg[in_ch.instruction[20:16]];
        end
    end

    // Operand forwarding: result stage, then last write-back, then the file, then the reset value
    assign s1_rs = s1_ins_reg[25:21];
    assign s1_rt = s1_ins_reg[20:16];

    always_comb
    begin
        if (s2_vld_reg && s2_we_reg && s2_idx_reg == s1_rs)
        begin
            opa = s2_value;
        end
        else if (lc_vld_reg && lc_idx_reg == s1_rs)
        begin
            opa = lc_val_reg;
        end
        else if (s1_a_ok_reg)
        begin
            opa = rf_qa;
        end
        else
        begin
            opa = mscc_pkg::reg_reset_value(s1_rs);
        end
    end

    always_comb
    begin
        if (s2_vld_reg && s2_we_reg && s2_idx_reg == s1_rt)
        begin
            opb = s2_value;
        end
        else if (lc_vld_reg && lc_idx_reg == s1_rt)
        begin
            opb = lc_val_reg;
        end
        else if (s1_b_ok_reg)
        begin
            opb = rf_qb;
        end
        else
        begin
            opb = mscc_pkg::reg_reset_value(s1_rt);
        end
    end

    mscc_exec u_exec (
        .instruction (s1_ins_reg),
        .pc          (pc_reg),
        .a           (opa),
        .b           (opb),
        .res         (res)
    );

    // Data memory: word index wraps at the memory size
    assign dm_idx   = res.mem_address[mscc_pkg::DMEM_AW+1:2];
    assign dm_we    = clr_active_reg || (advance && s1_vld_reg && res.mem_write);
    assign dm_waddr = clr_active_reg ? clr_addr_reg : dm_idx;
    assign dm_wdata = clr_active_reg ? 32'd0 : opb;
    assign dm_re    = advance && s1_vld_reg && res.mem_read;

    mscc_ram #(.WIDTH(32), .DEPTH(mscc_pkg::DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (dm_idx),
        .rdata (dm_q)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_vld_reg)
        begin
            s2_next_pc_reg <= res.next_pc;
            s2_we_reg      <= res.reg_write;
            s2_idx_reg     <= res.reg_index;
            s2_val_reg     <= res.reg_value;
            s2_load_reg    <= res.mem_read;
            s2_mw_reg      <= res.mem_write;
            s2_maddr_reg   <= res.mem_address;
            s2_taken_reg   <= res.branch_taken;
            s2_cls_reg     <= res.inst_class;
        end
    end

    // Loads take their value from the memory read register
    assign s2_value = s2_load_reg ? dm_q : s2_val_reg;

    assign out_ch.valid         = s2_vld_reg;
    assign out_ch.fetch_address = s2_next_pc_reg;
    assign out_ch.halted        = (s2_next_pc_reg == mscc_pkg::HALT_PC);
    assign out_ch.reg_write     = s2_we_reg;
    assign out_ch.reg_index     = s2_idx_reg;
    assign out_ch.reg_value     = s2_value;
    assign out_ch.mem_write     = s2_mw_reg;
    assign out_ch.mem_address   = s2_maddr_reg;
    assign out_ch.branch_taken  = s2_taken_reg;
    assign out_ch.inst_class    = s2_cls_reg;

    // The pc always matches the newest executed item
    a_pc_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> pc_reg == s2_next_pc_reg)
        else $error("pc out of step with result stage");

    // No item executes during the clearing pass
    a_no_exec_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_vld_reg && !s2_vld_reg)
        else $error("item in flight during memory clear");

    // Register zero is never written back, and no item that writes back is a store
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg && s2_we_reg |-> s2_idx_reg != mscc_pkg::REG_ZERO && !s2_mw_reg)
        else $error("bad write-back on result");

endmodule

[test/tb_top.sv]
// Self-checking bench for the MIPS single-cycle core: a directed program, then random streams.
`timescale 1ns / 1ps

module tb_top;

    // Opcodes and function codes that the core must treat as no-ops
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_LL    = 6'h30;
    localparam logic [5:0] OP_SC    = 6'h38;
    localparam logic [5:0] FN_SPARE = 6'h3F;

    localparam logic [13:0][5:0] R_FUNCS = {mscc_pkg::FN_ADD, mscc_pkg::FN_ADDU,
                                            mscc_pkg::FN_SUB, mscc_pkg::FN_SUBU,
                                            mscc_pkg::FN_AND, mscc_pkg::FN_OR,
                                            mscc_pkg::FN_NOR, mscc_pkg::FN_SLT,
                                            mscc_pkg::FN_SLTU, mscc_pkg::FN_SLL,
                                            mscc_pkg::FN_SRL, mscc_pkg::FN_JR,
                                            mscc_pkg::FN_JALR, FN_SPARE};
    localparam logic [6:0][5:0]  I_OPS   = {mscc_pkg::OP_ADDI, mscc_pkg::OP_ADDIU,
                                            mscc_pkg::OP_SLTI, mscc_pkg::OP_SLTIU,
                                            mscc_pkg::OP_ANDI, mscc_pkg::OP_ORI,
                                            mscc_pkg::OP_LUI};
    localparam logic [3:0][5:0]  DEAD_OPS = {OP_LB, OP_SB, OP_LL, OP_SC};

    localparam int RANDOM_PER_PHASE = 275;
    localparam int DRAIN_CYCLES     = 8;
    localparam int PRINT_CAP        = 40;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic        halted;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic        branch_taken;
        logic [1:0]  inst_class;
    } retire_t;

    typedef struct {
        logic [31:0] word;
        bit          typed;
        retire_t     want;
    } program_row_t;

    logic clk;
    logic rst_n;

    mscc_in_if  in_ch ();
    mscc_out_if out_ch ();

    mips_single_cycle_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Architectural state as the bench sees it
    logic [31:0] arch_pc;
    logic [31:0] arch_regs [mscc_pkg::RF_DEPTH];
    logic [31:0] arch_mem [int unsigned];

    retire_t      predicted_retires [$];
    program_row_t program_rows [$];
    retire_t      seen;
    retire_t      awaited;

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int retired;
    int items_sent;
    int stores_seen;
    int branches_seen;
    int halts_seen;

    int phase_idle  [4] = '{0, 76, 0, 14};
    int phase_stall [4] = '{0, 0, 76, 14};

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Instruction encoders
    function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd,
                                          input logic [4:0] sh);
        return {mscc_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] target);
        return {op, target};
    endfunction

    // Execute one instruction on the bench state and return what the core should retire
    function automatic retire_t execute_instruction(input logic [31:0] word);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm_z;
        logic [31:0] imm_s;
        logic [31:0] pc4;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] eff_addr;
        int unsigned slot;
        logic        wen;
        logic [4:0]  widx;
        logic [31:0] wval;
        retire_t     r;
        op       = word[31:26];
        rs       = word[25:21];
        rt       = word[20:16];
        rd       = word[15:11];
        sh       = word[10:6];
        fn       = word[5:0];
        imm_z    = {16'h0000, word[15:0]};
        imm_s    = {{16{word[15]}}, word[15:0]};
        pc4      = arch_pc + 32'd4;
        a        = arch_regs[rs];
        b        = arch_regs[rt];
        eff_addr = a + imm_s;
        slot     = (eff_addr >> 2) % mscc_pkg::DATA_WORDS;
        r        = '0;
        r.fetch_address = pc4;
        wen      = 1'b0;
        widx     = mscc_pkg::REG_ZERO;
        wval     = 32'd0;

        if (op == mscc_pkg::OP_RTYPE)
        begin
            widx = rd;
            wen  = 1'b1;
            case (fn) inside
                mscc_pkg::FN_ADD, mscc_pkg::FN_ADDU: wval = a + b;
                mscc_pkg::FN_SUB, mscc_pkg::FN_SUBU: wval = a - b;
                mscc_pkg::FN_AND:  wval = a & b;
                mscc_pkg::FN_OR:   wval = a | b;
                mscc_pkg::FN_NOR:  wval = ~(a | b);
                mscc_pkg::FN_SLT:  wval = {31'd0, $signed(a) < $signed(b)};
                mscc_pkg::FN_SLTU: wval = {31'd0, a < b};
                mscc_pkg::FN_SLL:  wval = b << sh;
                mscc_pkg::FN_SRL:  wval = b >> sh;
                mscc_pkg::FN_JR:
                begin
                    wen = 1'b0;
                    r.fetch_address = a;
                end
                mscc_pkg::FN_JALR:
                begin
                    wval = pc4;
                    r.fetch_address = a;
                end
                default: wen = 1'b0;
            endcase
        end
        else
        begin
            widx = rt;
            case (op) inside
                mscc_pkg::OP_ADDI, mscc_pkg::OP_ADDIU:
                begin
                    wen  = 1'b1;
                    wval = a + imm_s;
                end
                mscc_pkg::OP_ANDI:
                begin
                    wen  = 1'b1;
                    wval = a & imm_z;
                end
                mscc_pkg::OP_ORI:
                begin
                    wen  = 1'b1;
                    wval = a | imm_z;
                end
                mscc_pkg::OP_LUI:
                begin
                    wen  = 1'b1;
                    wval = {word[15:0], 16'h0000};
                end
                mscc_pkg::OP_SLTI:
                begin
                    wen  = 1'b1;
                    wval = {31'd0, $signed(a) < $signed(imm_s)};
                end
                mscc_pkg::OP_SLTIU:
                begin
                    wen  = 1'b1;
                    wval = {31'd0, a < imm_s};
                end
                mscc_pkg::OP_LW:
                begin
                    r.mem_address = eff_addr;
                    wen  = 1'b1;
                    wval = arch_mem.exists(slot) ? arch_mem[slot] : 32'd0;
                end
                mscc_pkg::OP_SW:
                begin
                    r.mem_address = eff_addr;
                    r.mem_write   = 1'b1;
                    arch_mem[slot] = b;
                end
                mscc_pkg::OP_BEQ, mscc_pkg::OP_BNE:
                begin
                    r.branch_taken = (op == mscc_pkg::OP_BEQ) ? (a == b) : (a != b);
                    if (r.branch_taken)
                    begin
                        r.fetch_address = pc4 + (imm_s << 2);
                    end
                end
                mscc_pkg::OP_J, mscc_pkg::OP_JAL:
                begin
                    r.fetch_address = {pc4[31:28], word[25:0], 2'b00};
                    if (op == mscc_pkg::OP_JAL)
                    begin
                        wen  = 1'b1;
                        widx = mscc_pkg::REG_RA;
                        wval = pc4 + 32'd4;
                    end
                end
                default: ;
            endcase
        end

        // Drop writes to register zero
        if (wen && widx != mscc_pkg::REG_ZERO)
        begin
            arch_regs[widx] = wval;
            r.reg_write = 1'b1;
            r.reg_index = widx;
            r.reg_value = wval;
        end
        arch_pc  = r.fetch_address;
        r.halted = (r.fetch_address == mscc_pkg::HALT_PC);
        if (word == 32'd0)
            r.inst_class = mscc_pkg::CLS_NOP;
        else if (op == mscc_pkg::OP_RTYPE)
            r.inst_class = mscc_pkg::CLS_R;
        else if (op == mscc_pkg::OP_J || op == mscc_pkg::OP_JAL)
            r.inst_class = mscc_pkg::CLS_J;
        else
            r.inst_class = mscc_pkg::CLS_I;
        return r;
    endfunction

    // Favour a few low registers so that results feed later instructions
    function automatic logic [4:0] pool_reg();
        return ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
    endfunction

    // Mostly well-formed instructions with random operands, some raw noise
    function automatic logic [31:0] random_instruction();
        int          pick;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  base;
        logic [15:0] imm;
        logic [15:0] offset;
        pick   = $urandom_range(99);
        rs     = pool_reg();
        rt     = pool_reg();
        rd     = pool_reg();
        imm    = ($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(31) - 16);
        offset = 16'($urandom_range(63) << 2);
        if ($urandom_range(7) == 0)
            offset = 16'($urandom);
        case ($urandom_range(2))
            0: base = mscc_pkg::REG_ZERO;
            1: base = mscc_pkg::REG_SP;
            default: base = rs;
        endcase
        if (pick < 8)
            return $urandom;
        else if (pick < 45)
            return enc_r(R_FUNCS[4'($urandom_range(13))], rs, rt, rd, 5'($urandom));
        else if (pick < 57)
            return enc_i(($urandom_range(1) == 0) ? mscc_pkg::OP_LW : mscc_pkg::OP_SW,
                         base, rt, offset);
        else if (pick < 65)
            return enc_i(($urandom_range(1) == 0) ? mscc_pkg::OP_BEQ : mscc_pkg::OP_BNE,
                         rs, rt, 16'($urandom_range(15) - 8));
        else if (pick < 70)
            return enc_j(($urandom_range(1) == 0) ? mscc_pkg::OP_J : mscc_pkg::OP_JAL,
                         26'($urandom));
        else if (pick < 74)
            return {DEAD_OPS[2'($urandom_range(3))], 26'($urandom)};
        else
            return enc_i(I_OPS[3'($urandom_range(6))], rs, rt, imm);
    endfunction

    task automatic add_row(input logic [31:0] word, input bit typed, input retire_t want);
        program_row_t row;
        row.word  = word;
        row.typed = typed;
        row.want  = want;
        program_rows.push_back(row);
    endtask

    // Offer one item, idling first at the phase's rate, and predict it once taken
    task automatic send_instruction(input logic [31:0] word, input bit typed,
                                    input retire_t want);
        retire_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.instruction <= word;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predicted = execute_instruction(word);
        predicted_retires.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Hold the sender until every predicted result has come back
    task automatic hold_until_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_retires.size() != 0);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch on result %0d: %s got %h expected %h", retired, what, got, exp);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] exp);
        if (got !== exp)
            flag_mismatch(what, got, exp);
    endtask

    // Receiver: stall at the phase's rate
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each retired item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.fetch_address = out_ch.fetch_address;
            seen.halted        = out_ch.halted;
            seen.reg_write     = out_ch.reg_write;
            seen.reg_index     = out_ch.reg_index;
            seen.reg_value     = out_ch.reg_value;
            seen.mem_write     = out_ch.mem_write;
            seen.mem_address   = out_ch.mem_address;
            seen.branch_taken  = out_ch.branch_taken;
            seen.inst_class    = out_ch.inst_class;
            if (predicted_retires.size() == 0)
            begin
                flag_mismatch("result with nothing outstanding", seen.fetch_address, 32'd0);
            end
            else
            begin
                awaited = predicted_retires.pop_front();
                check_field("fetch_address", seen.fetch_address, awaited.fetch_address);
                check_field("halted", 32'(seen.halted), 32'(awaited.halted));
                check_field("reg_write", 32'(seen.reg_write), 32'(awaited.reg_write));
                check_field("reg_index", 32'(seen.reg_index), 32'(awaited.reg_index));
                check_field("reg_value", seen.reg_value, awaited.reg_value);
                check_field("mem_write", 32'(seen.mem_write), 32'(awaited.mem_write));
                check_field("mem_address", seen.mem_address, awaited.mem_address);
                check_field("branch_taken", 32'(seen.branch_taken),
                            32'(awaited.branch_taken));
                check_field("inst_class", 32'(seen.inst_class), 32'(awaited.inst_class));
            end
            retired++;
            stores_seen   += seen.mem_write;
            branches_seen += seen.branch_taken;
            halts_seen    += seen.halted;
        end
    end

    // Main sequence
    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.instruction = 32'd0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        mismatches        = 0;
        retired           = 0;
        items_sent        = 0;
        stores_seen       = 0;
        branches_seen     = 0;
        halts_seen        = 0;

        // Directed program: reset state, halt and run-on, every operation, edge cases
        add_row(enc_r(mscc_pkg::FN_SLL, 0, 0, 0, 0), 1'b1,
                '{fetch_address: 32'h4, inst_class: mscc_pkg::CLS_NOP, default: '0});
        add_row(enc_r(mscc_pkg::FN_JR, mscc_pkg::REG_RA, 0, 0, 0), 1'b1,
                '{fetch_address: mscc_pkg::HALT_PC, halted: 1'b1,
                  inst_class: mscc_pkg::CLS_R, default: '0});
        add_row(enc_i(mscc_pkg::OP_ADDIU, 0, 1, 16'hFFFF), 1'b1,
                '{fetch_address: 32'h3, reg_write: 1'b1, reg_index: 5'd1,
                  reg_value: 32'hFFFF_FFFF, inst_class: mscc_pkg::CLS_I, default: '0});
        add_row(enc_i(mscc_pkg::OP_LUI, 0, 2, 16'h8000), 1'b1,
                '{fetch_address: 32'h7, reg_write: 1'b1, reg_index: 5'd2,
                  reg_value: 32'h8000_0000, inst_class: mscc_pkg::CLS_I, default: '0});
        add_row(enc_i(mscc_pkg::OP_ADDIU, 1, mscc_pkg::REG_ZERO, 16'h0005), 1'b1,
                '{fetch_address: 32'hB, inst_class: mscc_pkg::CLS_I, default: '0});
        add_row(enc_r(mscc_pkg::FN_ADD, 1, 2, 3, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_ADDU, 2, 2, 4, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SUB, 2, 1, 5, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SUBU, 0, 1, 6, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_AND, 1, 2, 7, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_OR, 2, 1, 8, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_NOR, 0, 0, 9, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SLT, 2, 0, 10, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SLTU, 2, 0, 11, 0), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SLL, 0, 1, 12, 31), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_SRL, 0, 1, 13, 31), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_ADDI, 2, 14, 16'h8000), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_SLTI, 2, 15, 16'h7FFF), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_SLTIU, 0, 16, 16'hFFFF), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_ANDI, 1, 17, 16'hFFFF), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_ORI, 2, 18, 16'hFFFF), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_SW, 0, 1, 16'h0000), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_LUI, 0, 19, 16'h0004), 1'b0, '0);
        // Unaligned store one memory size up lands on word zero
        add_row(enc_i(mscc_pkg::OP_SW, 19, 2, 16'h0003), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_LW, 0, 20, 16'h0001), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_LW, mscc_pkg::REG_SP, 21, 16'hFFFC), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_BEQ, 0, 0, 16'hFFFF), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_BNE, 0, 0, 16'h0005), 1'b0, '0);
        add_row(enc_i(mscc_pkg::OP_BNE, 1, 0, 16'h0002), 1'b0, '0);
        add_row(enc_j(mscc_pkg::OP_JAL, 26'h3FF_FFFF), 1'b0, '0);
        add_row(enc_r(mscc_pkg::FN_JALR, 2, 0, 22, 0), 1'b0, '0);
        add_row(enc_j(mscc_pkg::OP_J, 26'h000_0000), 1'b0, '0);
        add_row({OP_LB, 26'h3FF_FFFF}, 1'b0, '0);
        add_row(enc_r(FN_SPARE, 1, 2, 23, 0), 1'b0, '0);

        // Release reset; the core then clears its memory
        repeat (3) @(posedge clk);
        rst_n   <= 1'b1;
        arch_pc  = 32'd0;
        for (int i = 0; i < mscc_pkg::RF_DEPTH; i++)
            arch_regs[5'(i)] = mscc_pkg::reg_reset_value(5'(i));
        arch_mem.delete();

        foreach (program_rows[i])
            send_instruction(program_rows[i].word, program_rows[i].typed, program_rows[i].want);
        hold_until_drained();

        // Random streams under each idling pattern, drained in between
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = phase_idle[2'(phase)];
            stall_pct     = phase_stall[2'(phase)];
            repeat (RANDOM_PER_PHASE)
                send_instruction(random_instruction(), 1'b0, '0);
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d instructions (directed program plus four idling phases)", items_sent);
        $display("checked %0d results: %0d stores, %0d taken branches, %0d halts, %0d mismatches",
                 retired, stores_seen, branches_seen, halts_seen, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: covers the memory clearing pass and the slowest idling phases
    initial
    begin
        #(5_000_000);
        $display("timeout with %0d results outstanding", predicted_retires.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
